// ===== rtl/closest_approach_kill_test_defines.svh =====
// Assertion macros shared by the closest approach kill test RTL.
`ifndef CLOSEST_APPROACH_KILL_TEST_DEFINES_SVH
`define CLOSEST_APPROACH_KILL_TEST_DEFINES_SVH

`define CAKT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define CAKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/cakt_pkg.sv =====
// Shared types and constants of the closest approach kill test.
package cakt_pkg;

  localparam int PW  = 28;
  localparam int VW  = 18;
  localparam int TSW = 11;
  localparam int KRW = 16;
  localparam int MW  = 62;
  localparam int QW  = 58;

  typedef enum logic [1:0] {
    AT_NONE   = 2'd0,
    AT_START  = 2'd1,
    AT_END    = 2'd2,
    AT_INSIDE = 2'd3
  } where_t;

  typedef enum logic {
    REG_TIME_STEP = 1'b0,
    REG_HIT_RANGE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    where_t        where;
    logic [59:0]   len2;
    logic [117:0]  num;
    logic [79:0]   ssq;
    logic [57:0]   psq;
  } geo_t;

  typedef struct packed {
    where_t        where;
    logic [QW-1:0] q;
    logic [59:0]   rem;
    logic [59:0]   alt_dist;
    logic          alt_zero;
  } quo_t;

endpackage

// ===== rtl/cakt_front.sv =====
// Geometry pipeline: relative state, dot and cross products and squared sums.
module cakt_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [2:0][cakt_pkg::PW-1:0]          ipos,
  input  logic [2:0][cakt_pkg::PW-1:0]          tpos,
  input  logic [2:0][cakt_pkg::VW-1:0]          ivel,
  input  logic [2:0][cakt_pkg::VW-1:0]          tvel,
  input  logic [cakt_pkg::TSW-1:0]              time_step,
  output logic                                  out_valid,
  output cakt_pkg::geo_t                        out_geo
);
  import cakt_pkg::*;

  logic [6:0] vld;

  logic signed [PW:0]   p1 [3];
  logic signed [VW:0]   dv1 [3];
  logic signed [PW:0]   p2 [3];
  logic signed [29:0]   dd2 [3];
  logic signed [58:0]   pdd3 [3];
  logic [57:0]          ddsq3 [3];
  logic [55:0]          psq3 [3];
  logic signed [58:0]   xa3 [3];
  logic signed [58:0]   xb3 [3];
  logic signed [39:0]   v3 [3];
  logic [59:0]          len2_4;
  logic signed [60:0]   r4;
  logic [57:0]          psq4;
  logic [57:0]          cm4 [3];
  logic [38:0]          vm4 [3];
  logic [57:0]          cm_next [3];
  logic [38:0]          vm_next [3];
  logic signed [59:0]   c_diff [3];
  where_t               where5;
  where_t               where_next;
  logic [50:0]          ceil_len;
  logic [59:0]          len2_5;
  logic [57:0]          psq5;
  logic [55:0]          chh5 [3];
  logic [57:0]          chl5 [3];
  logic [59:0]          cll5 [3];
  logic [17:0]          vhh5 [3];
  logic [38:0]          vhl5 [3];
  logic [59:0]          vll5 [3];
  where_t               where6;
  logic [59:0]          len2_6;
  logic [57:0]          psq6;
  logic [115:0]         csq6 [3];
  logic [77:0]          vsq6 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  assign out_valid = vld[6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_diff[i]  = 60'(xa3[i]) - 60'(xb3[i]);
      cm_next[i] = c_diff[i][59] ? 58'(-c_diff[i]) : 58'(c_diff[i]);
      vm_next[i] = v3[i][39] ? 39'(-v3[i]) : 39'(v3[i]);
    end
    ceil_len = 51'((61'(len2_4) + 61'd1023) >> 10);
    if (len2_4 == '0) begin
      where_next = AT_NONE;
    end else if (r4 <= 0) begin
      where_next = AT_END;
    end else if (r4 >= $signed({10'b0, ceil_len})) begin
      where_next = AT_START;
    end else begin
      where_next = AT_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1[i]   <= $signed({ipos[i][PW-1], ipos[i]}) - $signed({tpos[i][PW-1], tpos[i]});
        dv1[i]  <= $signed({ivel[i][VW-1], ivel[i]}) - $signed({tvel[i][VW-1], tvel[i]});
        p2[i]   <= p1[i];
        dd2[i]  <= dv1[i] * $signed({1'b0, time_step});
        pdd3[i] <= p2[i] * dd2[i];
        ddsq3[i] <= dd2[i] * dd2[i];
        psq3[i] <= p2[i] * p2[i];
        v3[i]   <= {p2[i][PW], p2[i], 10'b0} - {{10{dd2[i][29]}}, dd2[i]};
        cm4[i]  <= cm_next[i];
        vm4[i]  <= vm_next[i];
        chh5[i] <= cm4[i][57:30] * cm4[i][57:30];
        chl5[i] <= cm4[i][57:30] * cm4[i][29:0];
        cll5[i] <= cm4[i][29:0] * cm4[i][29:0];
        vhh5[i] <= vm4[i][38:30] * vm4[i][38:30];
        vhl5[i] <= vm4[i][38:30] * vm4[i][29:0];
        vll5[i] <= vm4[i][29:0] * vm4[i][29:0];
        csq6[i] <= (116'(chh5[i]) << 60) + (116'(chl5[i]) << 31) + 116'(cll5[i]);
        vsq6[i] <= (78'(vhh5[i]) << 60) + (78'(vhl5[i]) << 31) + 78'(vll5[i]);
      end
      xa3[0] <= p2[1] * dd2[2];
      xb3[0] <= p2[2] * dd2[1];
      xa3[1] <= p2[2] * dd2[0];
      xb3[1] <= p2[0] * dd2[2];
      xa3[2] <= p2[0] * dd2[1];
      xb3[2] <= p2[1] * dd2[0];
      len2_4 <= 60'(ddsq3[0]) + 60'(ddsq3[1]) + 60'(ddsq3[2]);
      r4     <= 61'(pdd3[0]) + 61'(pdd3[1]) + 61'(pdd3[2]);
      psq4   <= 58'(psq3[0]) + 58'(psq3[1]) + 58'(psq3[2]);
      where5 <= where_next;
      len2_5 <= len2_4;
      psq5   <= psq4;
      where6 <= where5;
      len2_6 <= len2_5;
      psq6   <= psq5;
      out_geo.where <= where6;
      out_geo.len2  <= len2_6;
      out_geo.psq   <= psq6;
      out_geo.num   <= 118'(csq6[0]) + 118'(csq6[1]) + 118'(csq6[2]);
      out_geo.ssq   <= 80'(vsq6[0]) + 80'(vsq6[1]) + 80'(vsq6[2]);
    end
  end

endmodule

// ===== rtl/cakt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module cakt_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  cakt_pkg::geo_t in_geo,
  output logic           out_valid,
  output cakt_pkg::quo_t out_quo
);
  import cakt_pkg::*;

  typedef struct packed {
    where_t        where;
    logic [59:0]   d;
    logic [59:0]   rem;
    logic [QW-1:0] nlo;
    logic [QW-1:0] q;
    logic [59:0]   alt_dist;
    logic          alt_zero;
  } div_t;

  function automatic div_t div_step(input div_t s);
    logic [60:0] t;
    logic        ge;
    div_t        r;
    t  = {s.rem, s.nlo[QW-1]};
    ge = t >= {1'b0, s.d};
    r  = s;
    r.rem = ge ? 60'(t - {1'b0, s.d}) : t[59:0];
    r.nlo = s.nlo << 1;
    r.q   = {s.q[QW-2:0], ge};
    return r;
  endfunction

  div_t       st [QW+1];
  div_t       entry;
  logic [QW:0] vld;

  always_comb begin
    entry.where = in_geo.where;
    entry.d     = in_geo.len2;
    entry.rem   = in_geo.num[117:QW];
    entry.nlo   = in_geo.num[QW-1:0];
    entry.q     = '0;
    if (in_geo.where == AT_START) begin
      entry.alt_dist = in_geo.ssq[79:20];
      entry.alt_zero = in_geo.ssq[19:0] == '0;
    end else begin
      entry.alt_dist = {2'b0, in_geo.psq};
      entry.alt_zero = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= entry;
      for (int k = 1; k <= QW; k++) begin
        st[k] <= div_step(st[k-1]);
      end
    end
  end

  assign out_valid        = vld[QW];
  assign out_quo.where    = st[QW].where;
  assign out_quo.q        = st[QW].q;
  assign out_quo.rem      = st[QW].rem;
  assign out_quo.alt_dist = st[QW].alt_dist;
  assign out_quo.alt_zero = st[QW].alt_zero;

endmodule

// ===== rtl/closest_approach_kill_test.sv =====
// Top level of the closest approach kill test with config registers and output skid.
//
// One transfer on the input channel carries an interceptor and a target state;
// exactly one result transfer follows with hit, miss_dist_sq and closest_at.
// Items may be presented every cycle: one item per cycle is accepted while
// the output side keeps up. From input transfer to result valid an item passes
// 7 geometry stages, 59 divider stages (an entry register, then 58 quotient bits)
// and the result register. The divider depth is set by the 58-bit quotient.
// When the receiver stalls, the pending result moves into a one-entry skid
// register and the pipeline keeps running for that cycle; while the skid
// register is full the pipeline holds and in_ready is low. Nothing is lost.
// Config writes (index 0 time step, 1 hit range) are always accepted and
// are meant to happen only while no item is in flight.
// Reset empties the pipeline and skid register and sets the time step to 16
// and the hit range to 320.
`include "closest_approach_kill_test_defines.svh"
module closest_approach_kill_test (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [cakt_pkg::PW-1:0]  int_x,
  input  logic [cakt_pkg::PW-1:0]  int_y,
  input  logic [cakt_pkg::PW-1:0]  int_z,
  input  logic [cakt_pkg::VW-1:0]  int_vx,
  input  logic [cakt_pkg::VW-1:0]  int_vy,
  input  logic [cakt_pkg::VW-1:0]  int_vz,
  input  logic [cakt_pkg::PW-1:0]  tgt_x,
  input  logic [cakt_pkg::PW-1:0]  tgt_y,
  input  logic [cakt_pkg::PW-1:0]  tgt_z,
  input  logic [cakt_pkg::VW-1:0]  tgt_vx,
  input  logic [cakt_pkg::VW-1:0]  tgt_vy,
  input  logic [cakt_pkg::VW-1:0]  tgt_vz,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     hit,
  output logic [cakt_pkg::MW-1:0]  miss_dist_sq,
  output logic [1:0]               closest_at,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [cakt_pkg::KRW-1:0] cfg_data
);
  import cakt_pkg::*;

  logic [TSW-1:0] time_step;
  logic [KRW-1:0] hit_range;
  logic           en;
  logic           front_valid;
  geo_t           front_geo;
  logic           div_valid;
  quo_t           div_quo;
  logic [MW-1:0]  dsq;
  logic           rem_zero;
  logic [31:0]    kr2;
  logic           vld_l;
  logic           hit_l;
  logic [MW-1:0]  dist_l;
  where_t         at_l;
  logic           skid_full;
  logic           hit_s;
  logic [MW-1:0]  dist_s;
  where_t         at_s;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TSW'(16);
      hit_range <= KRW'(320);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_TIME_STEP: time_step <= cfg_data[TSW-1:0];
        REG_HIT_RANGE: hit_range <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !skid_full;
  assign in_ready = en;

  cakt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .ipos      ({int_z, int_y, int_x}),
    .tpos      ({tgt_z, tgt_y, tgt_x}),
    .ivel      ({int_vz, int_vy, int_vx}),
    .tvel      ({tgt_vz, tgt_vy, tgt_vx}),
    .time_step (time_step),
    .out_valid (front_valid),
    .out_geo   (front_geo)
  );

  cakt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_geo    (front_geo),
    .out_valid (div_valid),
    .out_quo   (div_quo)
  );

  always_comb begin
    if (div_quo.where == AT_INSIDE) begin
      dsq      = {4'b0, div_quo.q};
      rem_zero = div_quo.rem == '0;
    end else begin
      dsq      = {2'b0, div_quo.alt_dist};
      rem_zero = div_quo.alt_zero;
    end
    kr2 = hit_range * hit_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_l     <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (en) begin
        vld_l <= div_valid;
      end
      if (skid_full) begin
        if (out_ready) begin
          skid_full <= 1'b0;
        end
      end else if (vld_l && !out_ready) begin
        skid_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_l  <= (dsq < MW'(kr2)) || ((dsq == MW'(kr2)) && rem_zero);
      dist_l <= dsq;
      at_l   <= div_quo.where;
    end
    if (!skid_full && vld_l && !out_ready) begin
      hit_s  <= hit_l;
      dist_s <= dist_l;
      at_s   <= at_l;
    end
  end

  assign out_valid    = skid_full || vld_l;
  assign hit          = skid_full ? hit_s : hit_l;
  assign miss_dist_sq = skid_full ? dist_s : dist_l;
  assign closest_at   = skid_full ? at_s : at_l;

  `CAKT_ASSERT_NOW(a_skid_blocks_input, clk, rst, skid_full, !in_ready)
  `CAKT_ASSERT_NEXT(a_skid_holds, clk, rst, skid_full && !out_ready, skid_full)
  `CAKT_ASSERT_NEXT(a_stall_fills_skid, clk, rst, !skid_full && vld_l && !out_ready, skid_full)

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the closest approach kill test block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cakt_pkg::*;

  localparam logic signed [255:0] MISS_MAX = (256'sd1 <<< 62) - 256'sd1;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic signed [PW-1:0] ipos[3];
    logic signed [VW-1:0] ivel[3];
    logic signed [PW-1:0] tpos[3];
    logic signed [VW-1:0] tvel[3];
  } pair_t;

  typedef struct {
    logic          hit;
    logic [MW-1:0] miss;
    where_t        where;
  } verdict_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic hit, cfg_valid, cfg_ready, cfg_index;
  logic [MW-1:0] miss_dist_sq;
  logic [1:0] closest_at;
  logic [KRW-1:0] cfg_data;
  pair_t cur_pair;

  logic [TSW-1:0] step_len;
  logic [KRW-1:0] radius;
  pair_t pair_q[$];
  verdict_t verdict_q[$];
  int errors;
  int idle_cycles;
  int burst_left, gap_left, stall_mode, mode_left;

  closest_approach_kill_test uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .int_x(cur_pair.ipos[0]), .int_y(cur_pair.ipos[1]), .int_z(cur_pair.ipos[2]),
    .int_vx(cur_pair.ivel[0]), .int_vy(cur_pair.ivel[1]), .int_vz(cur_pair.ivel[2]),
    .tgt_x(cur_pair.tpos[0]), .tgt_y(cur_pair.tpos[1]), .tgt_z(cur_pair.tpos[2]),
    .tgt_vx(cur_pair.tvel[0]), .tgt_vy(cur_pair.tvel[1]), .tgt_vz(cur_pair.tvel[2]),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .miss_dist_sq(miss_dist_sq), .closest_at(closest_at),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic verdict_t predict_kill(pair_t pr, logic [TSW-1:0] ts,
                                            logic [KRW-1:0] kr);
    logic signed [255:0] p[3], dd[3], v[3];
    logic signed [255:0] len2, rr, s, dsq, rem, kr2;
    verdict_t vd;
    len2 = 0;
    rr = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = pr.ipos[i] - pr.tpos[i];
      dd[i] = (pr.ivel[i] - pr.tvel[i]) * $signed({1'b0, ts});
    end
    for (int i = 0; i < 3; i++) begin
      len2 += dd[i] * dd[i];
      rr += p[i] * dd[i];
    end
    if (len2 == 0 || rr <= 0) begin
      vd.where = (len2 == 0) ? AT_NONE : AT_END;
      dsq = p[0] * p[0] + p[1] * p[1] + p[2] * p[2];
      rem = 0;
    end else if (rr >= ((len2 + 1023) >>> 10)) begin
      vd.where = AT_START;
      for (int i = 0; i < 3; i++) v[i] = p[i] * 1024 - dd[i];
      s = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      rem = s & 256'hFFFFF;
      dsq = s >>> 20;
    end else begin
      vd.where = AT_INSIDE;
      v[0] = p[1] * dd[2] - p[2] * dd[1];
      v[1] = p[2] * dd[0] - p[0] * dd[2];
      v[2] = p[0] * dd[1] - p[1] * dd[0];
      s = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      dsq = s / len2;
      rem = s % len2;
    end
    if (dsq > MISS_MAX) dsq = MISS_MAX;
    kr2 = $signed({1'b0, kr}) * $signed({1'b0, kr});
    vd.hit = (dsq < kr2) || (dsq == kr2 && rem == 0);
    vd.miss = dsq[MW-1:0];
    return vd;
  endfunction

  function automatic longint pick(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo), 0));
  endfunction

  function automatic pair_t make_pair(longint ix, longint iy, longint iz, longint ivx,
                                      longint ivy, longint ivz, longint tx, longint ty,
                                      longint tz, longint tvx, longint tvy, longint tvz);
    pair_t pr;
    pr.ipos[0] = PW'(ix);  pr.ipos[1] = PW'(iy);  pr.ipos[2] = PW'(iz);
    pr.ivel[0] = VW'(ivx); pr.ivel[1] = VW'(ivy); pr.ivel[2] = VW'(ivz);
    pr.tpos[0] = PW'(tx);  pr.tpos[1] = PW'(ty);  pr.tpos[2] = PW'(tz);
    pr.tvel[0] = VW'(tvx); pr.tvel[1] = VW'(tvy); pr.tvel[2] = VW'(tvz);
    return pr;
  endfunction

  function automatic pair_t random_pair(logic [TSW-1:0] ts);
    pair_t pr;
    longint rv, f, off, n, m, tp, tv;
    int kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      if (kind < 20) begin
        pr.ipos[i] = PW'($urandom);
        pr.tpos[i] = PW'($urandom);
        pr.ivel[i] = VW'($urandom);
        pr.tvel[i] = (kind < 4) ? pr.ivel[i] : VW'($urandom);
      end else begin
        m = longint'(1) << $urandom_range(16, 0);
        n = longint'(1) << $urandom_range(12, 0);
        tp = pick(-(1 << 26), (1 << 26) - 1);
        tv = pick(-65536, 65535);
        rv = (kind < 28) ? 0 : pick(-m, m);
        f = $urandom_range(1100, 0);
        off = (rv * longint'(ts) * f) / (1024 * 1024) + pick(-n, n);
        pr.tpos[i] = PW'(tp);
        pr.tvel[i] = VW'(tv);
        pr.ipos[i] = PW'(tp + off);
        pr.ivel[i] = VW'(tv + rv);
      end
    end
    return pr;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [KRW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TIME_STEP) step_len = val[TSW-1:0];
    else radius = val;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pair_q.size() != 0 || in_valid || verdict_q.size() != 0);
  endtask

  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid)
        verdict_q.insert(verdict_q.size(), predict_kill(cur_pair, step_len, radius));
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pair_q.size() > 0) begin
        next_valid = 1'b1;
        cur_pair <= pair_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      in_valid <= next_valid;
    end
  end

  always @(posedge clk) begin
    verdict_t vd;
    if (rst) begin
      out_ready <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
      idle_cycles <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(2);
        mode_left <= $urandom_range(300, 20);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(1));
        default: out_ready <= ($urandom_range(7) == 0);
      endcase
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result transfer with no pending prediction");
          errors++;
        end else begin
          vd = verdict_q.pop_front();
          if (hit !== vd.hit) begin
            $error("hit: expected %0d, actual %0d", vd.hit, hit);
            errors++;
          end
          if (miss_dist_sq !== vd.miss) begin
            $error("miss_dist_sq: expected %0d, actual %0d", vd.miss, miss_dist_sq);
            errors++;
          end
          if (closest_at !== vd.where) begin
            $error("closest_at: expected %0d, actual %0d", vd.where, closest_at);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    logic [KRW-1:0] ts_set[9];
    logic [KRW-1:0] kr_set[9];
    longint pmax, pmin, vmax, vmin;
    pmax = (1 << 27) - 1;
    pmin = -(1 << 27);
    vmax = (1 << 17) - 1;
    vmin = -(1 << 17);
    ts_set = '{16, 1, 1024, 2047, 0, 300, 64, 16, 1000};
    kr_set = '{320, 0, 65535, 320, 1000, 5000, 65535, 40000, 1};
    errors = 0;
    step_len = TSW'(16);
    radius = KRW'(320);
    cur_pair = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    cfg_valid = 1'b0;
    cfg_index = REG_TIME_STEP;
    cfg_data = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    pair_q.insert(pair_q.size(), make_pair(pmax, pmax, pmax, vmax, vmax, vmax,
                                           pmin, pmin, pmin, vmin, vmin, vmin));
    pair_q.insert(pair_q.size(), make_pair(pmin, pmin, pmin, vmin, vmin, vmin,
                                           pmax, pmax, pmax, vmax, vmax, vmax));
    pair_q.insert(pair_q.size(), make_pair(pmax, pmin, pmax, vmin, vmax, vmin,
                                           pmin, pmax, pmin, vmax, vmin, vmax));
    pair_q.insert(pair_q.size(), make_pair(pmax, pmax, pmax, vmax, vmax, vmax,
                                           pmax, pmax, pmax, vmax, vmax, vmax));
    pair_q.insert(pair_q.size(), make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pair_q.insert(pair_q.size(), make_pair(320, 0, 0, 5, 5, 5, 0, 0, 0, 5, 5, 5));
    pair_q.insert(pair_q.size(), make_pair(321, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pair_q.insert(pair_q.size(), make_pair(1, 0, 0, 64, 0, 0, 0, 0, 0, 0, 0, 0));
    pair_q.insert(pair_q.size(), make_pair(0, 0, 0, 64, 0, 0, 0, 0, 0, 0, 0, 0));
    pair_q.insert(pair_q.size(), make_pair(-5000, 100, 0, 640, 0, 0, 0, 0, 0, 0, 0, 0));
    pair_q.insert(pair_q.size(), make_pair(40, 300, 0, 6400, 0, 0, 0, 0, 0, 0, 0, 0));
    pair_q.insert(pair_q.size(), make_pair(40, 10, 7, 6400, 100, -50, 0, 0, 0, 0, 0, 0));
    pair_q.insert(pair_q.size(), make_pair(5000, 5000, 5000, vmax, vmax, vmax,
                                           0, 0, 0, 0, 0, 0));
    pair_q.insert(pair_q.size(), make_pair(100, -100, 50, -vmax, 3, 0,
                                           90, -95, 49, vmax, 0, 0));
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      write_reg(REG_TIME_STEP, ts_set[ph]);
      write_reg(REG_HIT_RANGE, kr_set[ph]);
      @(negedge clk);
      for (int k = 0; k < 195; k++) pair_q.insert(pair_q.size(), random_pair(step_len));
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
